@@ sv/bu3x_pkg.sv @@
package bu3x_pkg;

  localparam int SCALE = 3;
  localparam int KW = 2 * SCALE - 1;
  localparam int OUT_CH = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [2:0] SPAN_SHORT = 3'(SCALE);
  localparam logic [2:0] SPAN_LONG = 3'(2 * SCALE);
  localparam logic [2:0] KW3 = 3'(KW);

  localparam logic [9:0] LOW_WIDTH_RESET = 10'd320;
  localparam logic [11:0] LOW_HEIGHT_RESET = 12'd240;

  // floor(s / 25) == (s * 5243) >> 17 for every s below 6400
  localparam logic [12:0] RECIP_25 = 13'd5243;
  localparam int RECIP_SHIFT = 17;

  typedef enum logic [0:0] {
    CFG_LOW_WIDTH = 1'b0,
    CFG_LOW_HEIGHT = 1'b1
  } cfg_addr_t;

  typedef logic [OUT_CH-1:0][7:0] pixel_t;

  typedef struct packed {
    pixel_t a;
    pixel_t b;
    pixel_t c;
    pixel_t d;
    logic [13:0] row_base;
    logic [10:0] col_base;
    logic long_i;
    logic long_j;
  } job_t;

  // a * b for a, b in 0..5
  localparam logic [4:0] PROD_TAB [0:5][0:5] = '{
    '{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5},
    '{5'd0, 5'd2, 5'd4, 5'd6, 5'd8, 5'd10},
    '{5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15},
    '{5'd0, 5'd4, 5'd8, 5'd12, 5'd16, 5'd20},
    '{5'd0, 5'd5, 5'd10, 5'd15, 5'd20, 5'd25}
  };

endpackage

@@ sv/bu3x_front.sv @@
module bu3x_front #(
  parameter int MAX_LINE = 512,
  parameter int CHANNELS = 3
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  bu3x_pkg::cfg_addr_t cfg_index,
  input  logic [bu3x_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  input  logic queue_full,
  output logic push,
  output bu3x_pkg::job_t job
);
  import bu3x_pkg::*;

  localparam int COL_W = $clog2(MAX_LINE);

  typedef logic [CHANNELS-1:0][7:0] lane_pix_t;

  logic [9:0] low_width;
  logic [11:0] low_height;
  logic [COL_W-1:0] col_count;
  logic [11:0] row_count;
  logic fresh;
  lane_pix_t left_pixel;
  lane_pix_t upper_left_pixel;
  lane_pix_t rd_data;
  lane_pix_t cur;
  lane_pix_t line_mem [MAX_LINE];

  logic [2:0][7:0] in_rgb;
  logic [12:0] wd_eff;
  logic [11:0] ht_eff;
  logic [12:0] c_plus;
  logic [12:0] r_plus;
  logic row_end;
  logic frame_end;
  logic accept;
  logic [11:0] h;
  logic [COL_W-1:0] w;

  assign in_rgb = {blue_in, green_in, red_in};

  for (genvar k = 0; k < CHANNELS; k++) begin : g_cur
    if (k < OUT_CH) begin : g_in
      assign cur[k] = in_rgb[k];
    end else begin : g_zero
      assign cur[k] = 8'd0;
    end
  end

  for (genvar k = 0; k < OUT_CH; k++) begin : g_job
    if (k < CHANNELS) begin : g_live
      assign job.a[k] = upper_left_pixel[k];
      assign job.b[k] = rd_data[k];
      assign job.c[k] = left_pixel[k];
      assign job.d[k] = cur[k];
    end else begin : g_dead
      assign job.a[k] = 8'd0;
      assign job.b[k] = 8'd0;
      assign job.c[k] = 8'd0;
      assign job.d[k] = 8'd0;
    end
  end

  always_comb begin
    if (low_width < 10'd2) begin
      wd_eff = 13'd2;
    end else if (13'(low_width) > 13'(MAX_LINE)) begin
      wd_eff = 13'(MAX_LINE);
    end else begin
      wd_eff = 13'(low_width);
    end
    ht_eff = (low_height < 12'd2) ? 12'd2 : low_height;
  end

  assign c_plus = 13'(col_count) + 13'd1;
  assign r_plus = 13'(row_count) + 13'd1;
  assign row_end = (c_plus >= wd_eff);
  assign frame_end = (r_plus >= 13'(ht_eff));

  // the line store read for the new column lands in the cycle after each transaction
  assign in_stall = !fresh || queue_full;
  assign accept = in_valid && !in_stall;
  assign push = accept && (row_count != 12'd0) && (col_count != '0);

  assign h = row_count - 12'd1;
  assign w = col_count - COL_W'(1);
  assign job.row_base = 14'(({2'b00, h} << 1) + {2'b00, h});
  assign job.col_base = 11'(({2'b00, w} << 1) + {2'b00, w});
  assign job.long_i = (r_plus == 13'(ht_eff));
  assign job.long_j = (c_plus == wd_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      low_width <= LOW_WIDTH_RESET;
      low_height <= LOW_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_LOW_WIDTH: low_width <= cfg_data[9:0];
        CFG_LOW_HEIGHT: low_height <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh <= 1'b0;
      col_count <= '0;
      row_count <= '0;
      left_pixel <= '0;
      upper_left_pixel <= '0;
    end else begin
      fresh <= !accept;
      if (accept) begin
        left_pixel <= cur;
        upper_left_pixel <= rd_data;
        if (row_end) begin
          col_count <= '0;
          row_count <= frame_end ? 12'd0 : r_plus[11:0];
        end else begin
          col_count <= c_plus[COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= line_mem[col_count];
    if (accept) begin
      line_mem[col_count] <= cur;
    end
  end

endmodule

@@ sv/bu3x_queue.sv @@
module bu3x_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  bu3x_pkg::job_t push_job,
  output logic full,
  input  logic pop,
  output logic job_valid,
  output bu3x_pkg::job_t head_job
);
  import bu3x_pkg::*;

  job_t entries [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign job_valid = (count != 2'd0);
  assign head_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

@@ sv/bu3x_back.sv @@
module bu3x_back (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  input  bu3x_pkg::job_t job,
  output logic pop,
  output logic out_valid,
  input  logic out_stall,
  output logic [13:0] out_row,
  output logic [10:0] out_col,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out,
  output logic last_of_run
);
  import bu3x_pkg::*;

  logic [2:0] i;
  logic [2:0] j;
  logic i_last;
  logic j_last;
  logic issue;
  logic out_ready;
  logic s1_ready;
  logic [4:0] wa, wb, wc, wd;
  logic [OUT_CH-1:0][12:0] sum_next;

  logic s1_valid;
  logic [13:0] s1_row;
  logic [10:0] s1_col;
  logic s1_last;
  logic [OUT_CH-1:0][12:0] s1_sum;

  logic [OUT_CH-1:0][25:0] scaled;

  assign i_last = (i == (job.long_i ? SPAN_LONG : SPAN_SHORT) - 3'd1);
  assign j_last = (j == (job.long_j ? SPAN_LONG : SPAN_SHORT) - 3'd1);

  assign out_ready = !out_valid || !out_stall;
  assign s1_ready = !s1_valid || out_ready;
  assign issue = job_valid && s1_ready;
  assign pop = issue && i_last && j_last;

  assign wa = PROD_TAB[KW3 - i][KW3 - j];
  assign wb = PROD_TAB[KW3 - i][j];
  assign wc = PROD_TAB[i][KW3 - j];
  assign wd = PROD_TAB[i][j];

  always_comb begin
    for (int k = 0; k < OUT_CH; k++) begin
      sum_next[k] = 13'(wa) * 13'(job.a[k]) + 13'(wb) * 13'(job.b[k])
                  + 13'(wc) * 13'(job.c[k]) + 13'(wd) * 13'(job.d[k]);
      scaled[k] = 26'(s1_sum[k]) * 26'(RECIP_25);
    end
  end

  // step j inside i over the block's offsets
  always_ff @(posedge clk) begin
    if (rst) begin
      i <= 3'd0;
      j <= 3'd0;
    end else if (issue) begin
      if (j_last) begin
        j <= 3'd0;
        i <= i_last ? 3'd0 : i + 3'd1;
      end else begin
        j <= j + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && issue) begin
      s1_row <= job.row_base + 14'(i);
      s1_col <= job.col_base + 11'(j);
      s1_last <= i_last && j_last;
      s1_sum <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_valid) begin
      out_row <= s1_row;
      out_col <= s1_col;
      last_of_run <= s1_last;
      red_out <= scaled[0][RECIP_SHIFT+7:RECIP_SHIFT];
      green_out <= scaled[1][RECIP_SHIFT+7:RECIP_SHIFT];
      blue_out <= scaled[2][RECIP_SHIFT+7:RECIP_SHIFT];
    end
  end

endmodule

@@ sv/bilinear_upscale_3x_core.sv @@
// 3x bilinear upscaler for a raster stream of RGB pixels.
// Input channel (in_valid/in_stall, red_in/green_in/blue_in): one low-res
// pixel per transaction in raster order. The front takes no pixel in the
// cycle after a transaction: the line store read for the next column lands
// in that cycle. Pixels in the first row or column yield nothing.
// Any other pixel completes a 2x2 corner set and queues one job; the back
// walks its offsets and, while out_stall is low, delivers one high-res pixel
// per cycle on the output channel (out_valid/out_stall), 9 per job, 18 along
// the last block row or column and 36 at the last block, last_of_run marking
// the final one. With the back idle, a job's results pass through the queue
// entry, the s1 register and the output register; with the back busy, the
// output path sets sustained throughput. A two-entry job queue lets the
// front keep accepting while the receiver holds out_stall, until it fills;
// a stalled result holds. Configuration (cfg_write/cfg_index/cfg_data)
// writes low_width and low_height; the user must write them only while
// idle, which the block does not enforce. Reset restores 320x240 and clears
// counters, queue and pipeline; the line store needs no clearing pass.
module bilinear_upscale_3x_core #(
  parameter int MAX_LINE = 512,
  parameter int CHANNELS = 3
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  bu3x_pkg::cfg_addr_t cfg_index,
  input  logic [bu3x_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  output logic out_valid,
  input  logic out_stall,
  output logic [13:0] out_row,
  output logic [10:0] out_col,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out,
  output logic last_of_run
);
  import bu3x_pkg::*;

  logic push;
  logic queue_full;
  logic pop;
  logic job_valid;
  job_t push_job;
  job_t head_job;

  bu3x_front #(
    .MAX_LINE(MAX_LINE),
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .red_in(red_in),
    .green_in(green_in),
    .blue_in(blue_in),
    .queue_full(queue_full),
    .push(push),
    .job(push_job)
  );

  bu3x_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_job(push_job),
    .full(queue_full),
    .pop(pop),
    .job_valid(job_valid),
    .head_job(head_job)
  );

  bu3x_back u_back (
    .clk(clk),
    .rst(rst),
    .job_valid(job_valid),
    .job(head_job),
    .pop(pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_row(out_row),
    .out_col(out_col),
    .red_out(red_out),
    .green_out(green_out),
    .blue_out(blue_out),
    .last_of_run(last_of_run)
  );

endmodule

@@ verif/tb_bilinear_upscale_3x_core.sv @@
module tb_bilinear_upscale_3x_core;
  import bu3x_pkg::*;

  localparam int LINE_DEPTH = 512;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_LIMIT = 200000;
  localparam int LONG_HOLD = 400;
  localparam int RANDOM_ITEMS = 450;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [13:0] row;
    logic [10:0] col;
    rgb_t px;
    logic last;
  } hires_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  cfg_addr_t cfg_index = CFG_LOW_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] red_in = '0;
  logic [7:0] green_in = '0;
  logic [7:0] blue_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [13:0] out_row;
  logic [10:0] out_col;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic last_of_run;

  bilinear_upscale_3x_core dut (.*);

  // upscaler state as the block should hold it
  rgb_t prev_row [LINE_DEPTH];
  bit prev_row_set [LINE_DEPTH];
  rgb_t left_px = '0;
  rgb_t upleft_px = '0;
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  logic [9:0] set_width = LOW_WIDTH_RESET;
  logic [11:0] set_height = LOW_HEIGHT_RESET;

  rgb_t pixel_q [$];
  hires_t hires_q [$];
  int fail_count = 0;

  int unsigned send_wait = 0;
  int unsigned take_wait = 0;
  bit send_burst = 1'b0;
  bit take_burst = 1'b0;
  bit hold_request = 1'b0;
  bit hold_seen = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int unsigned eff_width(input logic [9:0] w);
    if (w < 2) return 2;
    if (w > LINE_DEPTH) return LINE_DEPTH;
    return w;
  endfunction

  function automatic int unsigned eff_height(input logic [11:0] h);
    return (h < 2) ? 2 : h;
  endfunction

  function automatic logic [7:0] blend(input logic [7:0] a, b, c, d, input int i, j);
    int s;
    s = (KW - i) * (KW - j) * int'(a) + (KW - i) * j * int'(b)
      + i * (KW - j) * int'(c) + i * j * int'(d);
    return 8'(s / (KW * KW));
  endfunction

  // Consume one low-res pixel: emit the high-res block it completes, then advance.
  function automatic void upscale_pixel(input rgb_t cur);
    int unsigned wd, ht, h, w, ni, nj, i, j;
    rgb_t above;
    hires_t res;
    wd = eff_width(set_width);
    ht = eff_height(set_height);
    above = prev_row[col_pos];
    if (row_pos >= 1 && col_pos >= 1) begin
      h = row_pos - 1;
      w = col_pos - 1;
      ni = (h + 2 == ht) ? 2 * SCALE : SCALE;
      nj = (w + 2 == wd) ? 2 * SCALE : SCALE;
      for (i = 0; i < ni; i++) begin
        for (j = 0; j < nj; j++) begin
          res.row = 14'(SCALE * h + i);
          res.col = 11'(SCALE * w + j);
          res.px.red = blend(upleft_px.red, above.red, left_px.red, cur.red, i, j);
          res.px.green = blend(upleft_px.green, above.green, left_px.green, cur.green, i, j);
          res.px.blue = blend(upleft_px.blue, above.blue, left_px.blue, cur.blue, i, j);
          res.last = (i + 1 == ni) && (j + 1 == nj);
          hires_q.push_back(res);
        end
      end
    end
    upleft_px = above;
    left_px = cur;
    prev_row[col_pos] = cur;
    prev_row_set[col_pos] = 1'b1;
    if (col_pos + 1 >= wd) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= ht) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endfunction

  // A new width is safe unless a later row would read a line entry never written.
  function automatic bit width_fits(input logic [9:0] w);
    int unsigned k;
    if (row_pos == 0) return 1'b1;
    for (k = 0; k < eff_width(w); k++) begin
      if (!prev_row_set[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want, taken);
    if (taken !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, taken);
      fail_count++;
    end
  endfunction

  function automatic logic [7:0] rand_level();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void queue_pixel(input logic [7:0] r, g, b);
    pixel_q.push_back({r, g, b});
  endfunction

  task automatic write_reg(input cfg_addr_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_LOW_WIDTH) set_width = val[9:0];
    else set_height = val[11:0];
  endtask

  task automatic wait_drained();
    int unsigned spent;
    spent = 0;
    while ((pixel_q.size() != 0 || in_valid || hires_q.size() != 0)
           && spent < DRAIN_LIMIT) begin
      @(posedge clk);
      spent++;
    end
    // pixels with no result may still be inside the front end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : drive_pixels
    bit sent;
    sent = in_valid && !in_stall;
    if (rst) begin
      in_valid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (sent) begin
        upscale_pixel({red_in, green_in, blue_in});
        void'(pixel_q.pop_front());
      end
      // hold a stalled transaction unchanged
      if (!in_valid || sent) begin
        if (send_wait != 0) begin
          in_valid <= 1'b0;
          send_wait <= send_wait - 1;
        end else if (pixel_q.size() != 0) begin
          in_valid <= 1'b1;
          red_in <= pixel_q[0].red;
          green_in <= pixel_q[0].green;
          blue_in <= pixel_q[0].blue;
          send_wait <= send_burst ? 0 : $urandom_range(0, 8);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : take_results
    bit taken;
    int unsigned pause;
    hires_t want;
    taken = out_valid && !out_stall;
    if (rst) begin
      out_stall <= 1'b0;
      take_wait <= 0;
      hold_seen <= hold_request;
    end else begin
      if (taken) begin
        if (hires_q.size() == 0) begin
          $error("unexpected result at row %0d col %0d", out_row, out_col);
          fail_count++;
        end else begin
          want = hires_q.pop_front();
          compare_field("out_row", want.row, out_row);
          compare_field("out_col", want.col, out_col);
          compare_field("red_out", want.px.red, red_out);
          compare_field("green_out", want.px.green, green_out);
          compare_field("blue_out", want.px.blue, blue_out);
          compare_field("last_of_run", want.last, last_of_run);
        end
      end
      if (hold_seen != hold_request) begin
        hold_seen <= hold_request;
        out_stall <= 1'b1;
        take_wait <= LONG_HOLD;
      end else if (take_wait != 0) begin
        out_stall <= 1'b1;
        take_wait <= take_wait - 1;
      end else if (taken) begin
        pause = take_burst ? 0 : $urandom_range(0, 8);
        out_stall <= (pause != 0);
        take_wait <= (pause != 0) ? pause - 1 : 0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int unsigned k, n, fed, phase, wd, ht;
    logic [9:0] new_w;
    logic [11:0] new_h;
    for (k = 0; k < LINE_DEPTH; k++) begin
      prev_row[k] = '0;
      prev_row_set[k] = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // 2x2 image: the one interior pixel closes the last block in both directions
    write_reg(CFG_LOW_WIDTH, 12'd2);
    write_reg(CFG_LOW_HEIGHT, 12'd2);
    @(negedge clk);
    queue_pixel(8'hFF, 8'hFF, 8'hFF);
    queue_pixel(8'h00, 8'h00, 8'h00);
    queue_pixel(8'h00, 8'h00, 8'h00);
    queue_pixel(8'hFF, 8'hFF, 8'hFF);
    for (k = 0; k < 4; k++) queue_pixel(8'hFF, 8'hFF, 8'hFF);
    wait_drained();

    // out-of-range sizes saturate up to 2
    write_reg(CFG_LOW_WIDTH, 12'd0);
    write_reg(CFG_LOW_HEIGHT, 12'd1);
    @(negedge clk);
    queue_pixel(8'h01, 8'h80, 8'hFE);
    queue_pixel(8'h7F, 8'h00, 8'hFF);
    queue_pixel(8'hFF, 8'h01, 8'h80);
    queue_pixel(8'h00, 8'hFE, 8'h7F);
    wait_drained();

    // 3x3: plain block, last column, last row and last block
    write_reg(CFG_LOW_WIDTH, 12'd3);
    write_reg(CFG_LOW_HEIGHT, 12'd3);
    @(negedge clk);
    for (k = 0; k < 9; k++) queue_pixel(8'(k * 29), 8'(255 - k * 29), 8'(k * k * 3));
    wait_drained();

    // upper data bits drop, 1023 saturates to a full line; fills the whole line store
    write_reg(CFG_LOW_WIDTH, 12'hFFF);
    write_reg(CFG_LOW_HEIGHT, 12'd2);
    @(negedge clk);
    for (k = 0; k < LINE_DEPTH + 2; k++) queue_pixel(rand_level(), rand_level(), rand_level());

    fed = 0;
    phase = 0;
    while (fed < RANDOM_ITEMS) begin
      wait_drained();
      case ($urandom_range(0, 9))
        0: new_w = 10'($urandom_range(0, 1));
        default: new_w = 10'($urandom_range(2, 10));
      endcase
      case ($urandom_range(0, 9))
        0: new_h = 12'($urandom_range(0, 1));
        1: new_h = 12'hFFF;
        default: new_h = 12'($urandom_range(2, 6));
      endcase
      // tall frame early on, so a later phase shrinks it mid-image
      if (phase == 1) new_h = 12'hFFF;
      if ($urandom_range(0, 3) != 0 && width_fits(new_w)) write_reg(CFG_LOW_WIDTH, 12'(new_w));
      if (phase == 1 || $urandom_range(0, 3) != 0) write_reg(CFG_LOW_HEIGHT, new_h);

      wd = eff_width(set_width);
      ht = eff_height(set_height);
      if (ht > 6) ht = 6;
      n = wd * ht * $urandom_range(1, 2);
      if ($urandom_range(0, 3) == 0) n += $urandom_range(1, 2 * wd);
      send_burst = ($urandom_range(0, 3) == 0);
      take_burst = ($urandom_range(0, 3) == 0);
      if (phase % 6 == 2 && n < 40) n = 40;

      @(negedge clk);
      for (k = 0; k < n; k++) queue_pixel(rand_level(), rand_level(), rand_level());
      // stall the output for a long stretch while pixels keep coming
      if (phase % 6 == 2) begin
        send_burst = 1'b1;
        hold_request = ~hold_request;
      end
      fed += n;
      phase++;
    end

    wait_drained();
    if (hires_q.size() != 0) begin
      $error("%0d expected results never arrived", hires_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("bilinear_upscale_3x_core verification clean");
    end else begin
      $display("bilinear_upscale_3x_core verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #6000000;
    $display("bilinear_upscale_3x_core verification failed");
    $finish;
  end

endmodule
